/* rtl/falu_pkg.sv */
// Opcode and condition-code constants for the flag-keeping ALU.
// Used by flag_alu_with_condition_codes_core; no dependencies.
package falu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W   = 5;
    localparam int unsigned COND_W = 4;
    localparam int unsigned TGT_W  = 2;

    localparam logic [OP_W-1:0] OP_ADD        = 5'd0;
    localparam logic [OP_W-1:0] OP_ADDC       = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB        = 5'd2;
    localparam logic [OP_W-1:0] OP_SUBC       = 5'd3;
    localparam logic [OP_W-1:0] OP_CMP        = 5'd4;
    localparam logic [OP_W-1:0] OP_AND        = 5'd5;
    localparam logic [OP_W-1:0] OP_OR         = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR        = 5'd7;
    localparam logic [OP_W-1:0] OP_SLL        = 5'd8;
    localparam logic [OP_W-1:0] OP_SRL        = 5'd9;
    localparam logic [OP_W-1:0] OP_SRA        = 5'd10;
    localparam logic [OP_W-1:0] OP_EXTSB      = 5'd11;
    localparam logic [OP_W-1:0] OP_EXTSH      = 5'd12;
    localparam logic [OP_W-1:0] OP_TCOND      = 5'd13;
    localparam logic [OP_W-1:0] OP_TESTCOND   = 5'd14;
    localparam logic [OP_W-1:0] OP_BRANCHCOND = 5'd15;
    localparam logic [OP_W-1:0] OP_LOADCOUNT  = 5'd16;

    localparam logic [COND_W-1:0] CC_C    = 4'h0;
    localparam logic [COND_W-1:0] CC_NC   = 4'h1;
    localparam logic [COND_W-1:0] CC_HI   = 4'h2;
    localparam logic [COND_W-1:0] CC_LS   = 4'h3;
    localparam logic [COND_W-1:0] CC_Z    = 4'h4;
    localparam logic [COND_W-1:0] CC_NZ   = 4'h5;
    localparam logic [COND_W-1:0] CC_GT   = 4'h6;
    localparam logic [COND_W-1:0] CC_LE   = 4'h7;
    localparam logic [COND_W-1:0] CC_GE   = 4'h8;
    localparam logic [COND_W-1:0] CC_LT   = 4'h9;
    localparam logic [COND_W-1:0] CC_N    = 4'hA;
    localparam logic [COND_W-1:0] CC_NN   = 4'hB;
    localparam logic [COND_W-1:0] CC_V    = 4'hC;
    localparam logic [COND_W-1:0] CC_NV   = 4'hD;
    localparam logic [COND_W-1:0] CC_LOOP = 4'hE;
    localparam logic [COND_W-1:0] CC_AL   = 4'hF;

    localparam logic [TGT_W-1:0] TGT_ZERO = 2'd0;
    localparam logic [TGT_W-1:0] TGT_NEG  = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic              flag_update;
        logic [COND_W-1:0] cond_code;
        logic [TGT_W-1:0]  compare_target;
    } alu_op_t;

endpackage

/* rtl/flag_alu_with_condition_codes_core.sv */
// Top level of the flag-keeping 32-bit ALU with condition-code evaluation.
// Depends on falu_pkg.
//
// Usage:
//   Input channel s_*: s_tdata carries operand_a and operand_b, s_tuser the
//   opcode, flag_update, cond_code and compare_target. Result channel m_*:
//   m_tdata carries the result, m_tuser condition_met and the N Z C V T
//   flags as they stand after the word.
//   Each accepted word lands in an input register; combinational logic
//   computes the result, the new flags and the new loop count, and these
//   are written together into the result register and the status state.
//   Throughput is one word per cycle unless the receiver stalls: the
//   status state feeds straight back into the next word's logic, so
//   words may follow each other every clock.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word; s_tready drops only once both are
//   full, and no word is dropped or repeated.
//   Reset (aresetn low, synchronous) clears both stages, the flags and the
//   loop count.
module flag_alu_with_condition_codes_core
    import falu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [11:0] s_tuser,   // [4:0] opcode, [5] flag_update, [9:6] cond_code,
                                   // [11:10] compare_target
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result
    output logic [5:0]  m_tuser    // [0] condition_met, [1] N, [2] Z, [3] C, [4] V, [5] T
);

    logic              in_valid_reg;
    alu_op_t           in_op_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_result_reg;
    logic              out_met_reg;

    logic              n_reg, z_reg, c_reg, v_reg, t_reg;
    logic              n_next, z_next, c_next, v_next, t_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] result_next;
    logic              met_next;

    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // datapath
    logic [WORD_W-1:0] a, b, b_op, sum;
    logic              cin, sum_c, sum_v;
    logic [WORD_W:0]   sum_w;
    logic [4:0]        sa;
    logic [WORD_W:0]   sll_w, srl_w, sra_w;
    logic [WORD_W-1:0] count_dec;
    logic              cond;
    logic              is_sub;

    assign a  = in_op_reg.operand_a;
    assign b  = in_op_reg.operand_b;
    assign sa = b[4:0];

    always_comb begin
        is_sub = (in_op_reg.opcode == OP_SUB) || (in_op_reg.opcode == OP_SUBC)
                 || (in_op_reg.opcode == OP_CMP);
        b_op = is_sub ? ~b : b;
        unique case (in_op_reg.opcode)
            OP_ADDC, OP_SUBC: cin = c_reg;
            OP_SUB, OP_CMP:   cin = 1'b1;
            default:          cin = 1'b0;
        endcase
        sum_w = {1'b0, a} + {1'b0, b_op} + {{WORD_W{1'b0}}, cin};
        sum   = sum_w[WORD_W-1:0];
        sum_c = sum_w[WORD_W];
        sum_v = ((~(a ^ b_op)) & (a ^ sum)) >> (WORD_W - 1) != '0;
    end

    // bit 32 of sll_w and bit 0 of the right shifts are the last bit out
    assign sll_w = {1'b0, a} << sa;
    assign srl_w = {a, 1'b0} >> sa;
    assign sra_w = $unsigned($signed({a, 1'b0}) >>> sa);

    assign count_dec = count_reg - {{(WORD_W-1){1'b0}}, 1'b1};

    always_comb begin
        unique case (in_op_reg.cond_code)
            CC_C:    cond = c_reg;
            CC_NC:   cond = !c_reg;
            CC_HI:   cond = c_reg && !z_reg;
            CC_LS:   cond = !c_reg || z_reg;
            CC_Z:    cond = z_reg;
            CC_NZ:   cond = !z_reg;
            CC_GT:   cond = (n_reg == v_reg) && !z_reg;
            CC_LE:   cond = (n_reg != v_reg) || z_reg;
            CC_GE:   cond = n_reg == v_reg;
            CC_LT:   cond = n_reg != v_reg;
            CC_N:    cond = n_reg;
            CC_NN:   cond = !n_reg;
            CC_V:    cond = v_reg;
            CC_NV:   cond = !v_reg;
            CC_LOOP: cond = count_reg != '0;
            CC_AL:   cond = 1'b1;
        endcase
    end

    always_comb begin
        result_next = '0;
        met_next    = 1'b0;
        n_next      = n_reg;
        z_next      = z_reg;
        c_next      = c_reg;
        v_next      = v_reg;
        t_next      = t_reg;
        count_next  = count_reg;
        unique case (in_op_reg.opcode)
            OP_ADD, OP_ADDC, OP_SUB, OP_SUBC: begin
                result_next = sum;
                if (in_op_reg.flag_update) begin
                    n_next = sum[WORD_W-1];
                    z_next = sum == '0;
                    c_next = sum_c;
                    v_next = sum_v;
                end
            end
            OP_CMP: begin
                if (in_op_reg.flag_update) begin
                    n_next = sum[WORD_W-1];
                    z_next = sum == '0;
                    c_next = sum_c;
                    v_next = sum_v;
                    if (in_op_reg.compare_target == TGT_ZERO) begin
                        t_next = sum == '0;
                    end else if (in_op_reg.compare_target == TGT_NEG) begin
                        t_next = sum[WORD_W-1];
                    end
                end
            end
            OP_AND, OP_OR, OP_XOR, OP_EXTSB, OP_EXTSH: begin
                unique case (in_op_reg.opcode)
                    OP_AND:   result_next = a & b;
                    OP_OR:    result_next = a | b;
                    OP_XOR:   result_next = a ^ b;
                    OP_EXTSB: result_next = {{(WORD_W-8){a[7]}}, a[7:0]};
                    default:  result_next = {{(WORD_W-16){a[15]}}, a[15:0]};
                endcase
                if (in_op_reg.flag_update) begin
                    n_next = result_next[WORD_W-1];
                    z_next = result_next == '0;
                end
            end
            OP_SLL, OP_SRL, OP_SRA: begin
                unique case (in_op_reg.opcode)
                    OP_SLL: begin
                        result_next = sll_w[WORD_W-1:0];
                        c_next      = sll_w[WORD_W];
                    end
                    OP_SRL: begin
                        result_next = srl_w[WORD_W:1];
                        c_next      = srl_w[0];
                    end
                    default: begin
                        result_next = sra_w[WORD_W:1];
                        c_next      = sra_w[0];
                    end
                endcase
                if (in_op_reg.flag_update) begin
                    n_next = result_next[WORD_W-1];
                    z_next = result_next == '0;
                end else begin
                    c_next = c_reg;
                end
            end
            OP_TCOND: begin
                met_next = cond;
                t_next   = cond;
            end
            OP_TESTCOND: begin
                met_next = cond;
            end
            OP_BRANCHCOND: begin
                if (in_op_reg.cond_code == CC_LOOP) begin
                    if (count_reg != '0) begin
                        count_next = count_dec;
                        met_next   = count_dec != '0;
                    end
                end else begin
                    met_next = cond;
                end
            end
            OP_LOADCOUNT: begin
                count_next = a;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= 1'b0;
            z_reg         <= 1'b0;
            c_reg         <= 1'b0;
            v_reg         <= 1'b0;
            t_reg         <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                n_reg         <= n_next;
                z_reg         <= z_next;
                c_reg         <= c_next;
                v_reg         <= v_next;
                t_reg         <= t_next;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg.opcode         <= s_tuser[4:0];
            in_op_reg.flag_update    <= s_tuser[5];
            in_op_reg.cond_code      <= s_tuser[9:6];
            in_op_reg.compare_target <= s_tuser[11:10];
            in_op_reg.operand_a      <= s_tdata[31:0];
            in_op_reg.operand_b      <= s_tdata[63:32];
        end
        if (advance) begin
            out_result_reg <= result_next;
            out_met_reg    <= met_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;
    assign m_tuser  = {t_reg, v_reg, c_reg, z_reg, n_reg, out_met_reg};

endmodule
